### rtl/meu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// meu_pkg
// Shared types and constants of the modular exponentiation unit.
// ----------------------------------------------------------------------------
package meu_pkg;

   localparam int RES_W  = 30;
   localparam int BASE_W = 32;
   localparam int MU_W   = 31;

   localparam logic [RES_W-1:0] PRIME = 30'd1000000007;
   // floor(2^60 / PRIME), Barrett reciprocal
   localparam logic [MU_W-1:0]  MU    = 31'd1152921496;

   localparam logic [2:0] PH_FIRST = 3'd0;
   localparam logic [2:0] PH_MUL   = 3'd1;
   localparam logic [2:0] PH_LAST  = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef enum logic {
      KIND_SQ,
      KIND_MUL
   } kind_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
   } issue_type;

   typedef struct packed {
      logic             valid;
      kind_type         kind;
      logic [RES_W-1:0] value;
   } result_type;

endpackage
`default_nettype wire

### rtl/meu_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// meu_cell
// One exponent bit cell: loads its bit, then hands it down the row.
// ----------------------------------------------------------------------------
module meu_cell (
   input  wire logic clock,
   input  wire logic load,
   input  wire logic shift,
   input  wire logic load_bit,
   input  wire logic from_next,
   output logic      bit_q
);
   logic bit_ff;
   logic bit_in;

   always_comb begin
      bit_in = bit_ff;
      if (load) begin
         bit_in = load_bit;
      end else if (shift) begin
         bit_in = from_next;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   assign bit_q = bit_ff;

endmodule
`default_nettype wire

### rtl/meu_mulmod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// meu_mulmod
// Four-stage multiply and Barrett reduction modulo the prime.
// ----------------------------------------------------------------------------
module meu_mulmod (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire meu_pkg::issue_type              issue,
   input  wire logic [meu_pkg::BASE_W-1:0]      op_a,
   input  wire logic [meu_pkg::RES_W-1:0]       op_b,
   output meu_pkg::result_type                  res
);
   import meu_pkg::*;

   issue_type        v1_ff, v2_ff, v3_ff;
   result_type       res_ff;
   logic [59:0]      prod_ff;
   logic [MU_W-1:0]  q3_ff;
   logic [31:0]      lo2_ff, lo3_ff, qp_ff;

   logic [61:0]      prod_in;
   logic [61:0]      q2_in;
   logic [60:0]      qp_full;
   logic [31:0]      r0, r1, r2;

   always_comb begin
      prod_in = {30'd0, op_a} * {32'd0, op_b};
      q2_in   = {31'd0, prod_ff[59:29]} * {31'd0, MU};
      qp_full = {30'd0, q3_ff} * {31'd0, PRIME};
      r0      = lo3_ff - qp_ff;
      r1      = (r0 >= {2'd0, PRIME}) ? r0 - {2'd0, PRIME} : r0;
      r2      = (r1 >= {2'd0, PRIME}) ? r1 - {2'd0, PRIME} : r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff.valid  <= 1'b0;
         v2_ff.valid  <= 1'b0;
         v3_ff.valid  <= 1'b0;
         res_ff.valid <= 1'b0;
      end else begin
         v1_ff.valid  <= issue.valid;
         v2_ff.valid  <= v1_ff.valid;
         v3_ff.valid  <= v2_ff.valid;
         res_ff.valid <= v3_ff.valid;
      end
      v1_ff.kind   <= issue.kind;
      v2_ff.kind   <= v1_ff.kind;
      v3_ff.kind   <= v2_ff.kind;
      res_ff.kind  <= v3_ff.kind;
      prod_ff      <= prod_in[59:0];
      q3_ff        <= q2_in[61:31];
      lo2_ff       <= prod_ff[31:0];
      qp_ff        <= qp_full[31:0];
      lo3_ff       <= lo2_ff;
      res_ff.value <= r2[RES_W-1:0];
   end

   assign res = res_ff;

   a_res_reduced: assert property (@(posedge clock) disable iff (reset)
      res_ff.valid |-> res_ff.value < PRIME)
      else $error("mulmod result not reduced");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      res_ff.valid |-> $past(v1_ff.valid, 3))
      else $error("mulmod result without issue");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      r0 < 32'd3000000021 || !v3_ff.valid)
      else $error("Barrett estimate off by more than two");

endmodule
`default_nettype wire

### rtl/modular_exponentiation_unit_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation_unit_core
// base ** exponent mod 1000000007, right-to-left square-and-multiply.
//
//   channel  dir  beat fields
//   req      in   req_base, req_exponent
//   rsp      out  rsp_power
//
// One item at a time. Each exponent bit passes through the shared
// four-stage multiply/reduce pipeline (square, then multiply on a set bit).
// Synchronous active-high reset; no state kept between items.
// req_stall is high while an item is in work or its result waits on rsp_stall.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit_core #(
   parameter int EXPONENT_BITS = 63
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [meu_pkg::BASE_W-1:0]   req_base,
   input  wire logic [EXPONENT_BITS-1:0]     req_exponent,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [meu_pkg::RES_W-1:0]         rsp_power
);
   import meu_pkg::*;

   localparam int CNT_W = $clog2(EXPONENT_BITS + 1);

   state_type          state_ff, state_in;
   logic [2:0]         phase_ff, phase_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RES_W-1:0]   sq_ff, acc_ff;
   logic [BASE_W-1:0]  base_ff;

   logic               accept;
   logic               cell_shift;
   logic [EXPONENT_BITS:0] chain;
   issue_type          issue;
   logic [BASE_W-1:0]  op_a;
   logic [RES_W-1:0]   op_b;
   result_type         res;

   assign accept = req_valid && !req_stall;
   assign chain[EXPONENT_BITS] = 1'b0;

   for (genvar i = 0; i < EXPONENT_BITS; i++) begin : g_cell
      meu_cell u_cell (
         .clock     (clock),
         .load      (accept),
         .shift     (cell_shift),
         .load_bit  (req_exponent[i]),
         .from_next (chain[i+1]),
         .bit_q     (chain[i])
      );
   end

   meu_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .issue (issue),
      .op_a  (op_a),
      .op_b  (op_b),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_FIRST;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         base_ff <= req_base;
         acc_ff  <= RES_W'(1);
      end else if (res.valid && res.kind == KIND_MUL) begin
         acc_ff  <= res.value;
      end
      if (res.valid && res.kind == KIND_SQ) begin
         sq_ff <= res.value;
      end
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cell_shift  = 1'b0;
      issue.valid = 1'b0;
      issue.kind  = KIND_SQ;
      op_a        = {2'd0, sq_ff};
      op_b        = sq_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_LOAD;
               phase_in = PH_FIRST;
               cnt_in   = '0;
            end
         end
         ST_LOAD: begin
            if (phase_ff == PH_FIRST) begin
               issue.valid = 1'b1;
               op_a        = base_ff;
               op_b        = RES_W'(1);
            end
            if (phase_ff == PH_LAST) begin
               state_in = ST_RUN;
               phase_in = PH_FIRST;
            end else begin
               phase_in = phase_ff + 3'd1;
            end
         end
         ST_RUN: begin
            if (phase_ff == PH_FIRST) begin
               issue.valid = 1'b1;
            end
            if (phase_ff == PH_MUL) begin
               issue.valid = chain[0];
               issue.kind  = KIND_MUL;
               op_a        = {2'd0, acc_ff};
            end
            if (phase_ff == PH_LAST) begin
               cell_shift = 1'b1;
               phase_in   = PH_FIRST;
               cnt_in     = cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(EXPONENT_BITS - 1)) begin
                  state_in = ST_DONE;
               end
            end else begin
               phase_in = phase_ff + 3'd1;
            end
         end
         ST_DONE: begin
            if (phase_ff == PH_FIRST) begin
               phase_in = PH_MUL;
            end else begin
               rsp_valid = 1'b1;
               if (!rsp_stall) begin
                  state_in = ST_IDLE;
                  phase_in = PH_FIRST;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_power = acc_ff;

   a_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LOAD && acc_ff == RES_W'(1))
      else $error("item start did not seed accumulator");

   a_sq_phase: assert property (@(posedge clock) disable iff (reset)
      res.valid && res.kind == KIND_SQ |-> phase_ff == PH_LAST)
      else $error("square result out of phase");

   a_rsp_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_power < PRIME)
      else $error("result not reduced");

endmodule
`default_nettype wire

### test/modular_exponentiation_unit_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_unit_core_checker
// Watches the req and rsp channels of the exponentiation unit, computes the
// expected power of every accepted request beat and compares it with the
// oldest pending one when a response beat is accepted.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit_core_checker #(
   parameter int EXPONENT_BITS = 63
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_stall,
   input  wire logic [meu_pkg::BASE_W-1:0] req_base,
   input  wire logic [EXPONENT_BITS-1:0]   req_exponent,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire logic [meu_pkg::RES_W-1:0]  rsp_power,
   output int                              fail_count,
   output int                              pending_count,
   output int                              rsp_count
);

   localparam longint unsigned MODULUS = 64'd1000000007;

   logic [meu_pkg::RES_W-1:0] pending_powers[$];

   function automatic logic [meu_pkg::RES_W-1:0] power_mod_prime(
      input logic [meu_pkg::BASE_W-1:0] base,
      input logic [EXPONENT_BITS-1:0]   exponent
   );
      longint unsigned sq;
      longint unsigned acc;
      sq = 64'(base) % MODULUS;
      acc = 1;
      for (int i = 0; i < EXPONENT_BITS; i++) begin
         if (exponent[i]) acc = (acc * sq) % MODULUS;
         sq = (sq * sq) % MODULUS;
      end
      return acc[meu_pkg::RES_W-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      rsp_count = 0;
   end

   assign pending_count = pending_powers.size();

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            pending_powers.push_back(power_mod_prime(req_base, req_exponent));
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (pending_powers.size() == 0)
               report_mismatch("response beat with nothing pending");
            else if (pending_powers[0] !== rsp_power) begin
               report_mismatch($sformatf("power got %0d expected %0d",
                  rsp_power, pending_powers[0]));
               void'(pending_powers.pop_front());
            end else
               void'(pending_powers.pop_front());
         end
      end
   end

endmodule

### test/modular_exponentiation_unit_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_unit_core_tb
// Drives directed and random base/exponent beats into the exponentiation unit
// with random idle on req and random stall on rsp; the checker judges results.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit_core_tb;

   localparam int EXPONENT_BITS = 63;
   localparam int IDLE_LIMIT    = 5000;
   localparam int RANDOM_BEATS  = 1130;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [meu_pkg::BASE_W-1:0] req_base;
   logic [EXPONENT_BITS-1:0]   req_exponent;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [meu_pkg::RES_W-1:0]  rsp_power;
   int                         fail_count;
   int                         pending_count;
   int                         rsp_count;
   int                         idle_cycles;
   bit                         calm;

   modular_exponentiation_unit_core #(.EXPONENT_BITS(EXPONENT_BITS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_base(req_base), .req_exponent(req_exponent),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_power(rsp_power)
   );

   modular_exponentiation_unit_core_checker #(.EXPONENT_BITS(EXPONENT_BITS)) checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_base(req_base), .req_exponent(req_exponent),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_power(rsp_power),
      .fail_count(fail_count), .pending_count(pending_count), .rsp_count(rsp_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [EXPONENT_BITS-1:0] random_exponent();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return EXPONENT_BITS'($urandom_range(0, 3));
         1: return EXPONENT_BITS'(raw >> $urandom_range(0, 62));
         2: return '1;
         default: return raw[EXPONENT_BITS-1:0];
      endcase
   endfunction

   function automatic logic [meu_pkg::BASE_W-1:0] random_base();
      case ($urandom_range(0, 7))
         0: return 32'd1000000007 * $urandom_range(0, 4);
         1: return 32'($urandom_range(0, 2));
         2: return 32'd1000000006;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // one request beat; random idle before it unless in the calm stretch
   task automatic send_beat(input logic [meu_pkg::BASE_W-1:0] base,
                            input logic [EXPONENT_BITS-1:0] exponent);
      while (!calm && $urandom_range(0, 99) < 12) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_base <= base;
      req_exponent <= exponent;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock)
      rsp_stall <= !calm && $urandom_range(0, 99) < 12;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("FAIL modular_exponentiation_unit_core");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      logic [meu_pkg::BASE_W-1:0] bases[9];
      logic [EXPONENT_BITS-1:0]   exps[5];
      calm = 0;
      idle_cycles = 0;
      reset = 1;
      req_valid = 0;
      req_base = 0;
      req_exponent = 0;
      rsp_stall = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // zero exponent, prime multiples, extreme bases and exponents
      bases = '{32'd0, 32'd1, 32'd2, 32'd1000000006, 32'd1000000007,
                32'd2000000014, 32'hFFFFFFFF, 32'h80000000, 32'd12345};
      exps = '{'0, 63'd1, 63'd2, '1, 63'h4000000000000000};
      foreach (bases[b]) send_beat(bases[b], exps[b % 5]);
      foreach (exps[e]) send_beat(32'd0, exps[e]);
      foreach (exps[e]) send_beat(32'hFFFFFFFF, exps[e]);
      send_beat(32'd1000000007, '1);
      send_beat(32'd3, 63'h2AAAAAAAAAAAAAAA);
      send_beat(32'd3, 63'h5555555555555555);
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         calm = (i >= 400 && i < 550);
         send_beat(random_base(), random_exponent());
      end
      req_valid <= 0;
      calm = 0;
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("sent %0d request beats, checked %0d response beats",
               RANDOM_BEATS + 22, rsp_count);
      if (fail_count == 0 && pending_count == 0)
         $display("PASS modular_exponentiation_unit_core");
      else
         $display("FAIL modular_exponentiation_unit_core");
      $finish;
   end

endmodule
